@@ design/merge_sort_engine_assert.svh @@
// Assertion macros for the merge sort engine datapath.
// Users must have clk and rst_n in scope.
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define MSE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the trigger.
`define MSE_CHECK_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mse_pkg.sv @@
// Shared constants, types and helpers for the merge sort engine.
// No dependencies.
package mse_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int PTR_W        = CNT_W + 1;     // merge pointers and run width
    localparam int SUM_W        = PTR_W + 1;     // run-bound sums before clamping

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETUP,
        ST_MERGE,
        ST_EMIT
    } mse_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic merge;
        logic emit;
    } mse_cmd_t;

    typedef struct packed {
        logic last_acc;    // item marked last was accepted
        logic single;      // set has at most one element, nothing to merge
        logic sort_done;   // final merge step of final pass
        logic emit_done;   // final result loaded into output register
    } mse_stat_t;

    // Run bound limited to the element count.
    function automatic logic [PTR_W-1:0] clamp_n(input logic [SUM_W-1:0] x,
                                                 input logic [PTR_W-1:0] n);
        logic [SUM_W-1:0] n_w;
        n_w = SUM_W'(n);
        return (x > n_w) ? n : x[PTR_W-1:0];
    endfunction

endpackage

@@ design/mse_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// A read of the address being written returns the new data. No dependencies.
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // write-first: a pass may start by reading the entry just written
        rdata0 <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
        rdata1 <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
    end

endmodule

@@ design/mse_ctrl.sv @@
// Sequencer for the merge sort engine: load, setup, merge passes, emit.
// Depends on mse_pkg.
module mse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  mse_pkg::mse_stat_t stat,
    output mse_pkg::mse_cmd_t  cmd
);

    mse_pkg::mse_state_t state_reg;
    mse_pkg::mse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mse_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mse_pkg::ST_LOAD:
            begin
                if (stat.last_acc)
                begin
                    state_next = mse_pkg::ST_SETUP;
                end
            end
            mse_pkg::ST_SETUP:
            begin
                state_next = stat.single ? mse_pkg::ST_EMIT : mse_pkg::ST_MERGE;
            end
            mse_pkg::ST_MERGE:
            begin
                if (stat.sort_done)
                begin
                    state_next = mse_pkg::ST_EMIT;
                end
            end
            mse_pkg::ST_EMIT:
            begin
                if (stat.emit_done)
                begin
                    state_next = mse_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mse_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            mse_pkg::ST_LOAD:  cmd.load  = 1'b1;
            mse_pkg::ST_SETUP: cmd.setup = 1'b1;
            mse_pkg::ST_MERGE: cmd.merge = 1'b1;
            mse_pkg::ST_EMIT:  cmd.emit  = 1'b1;
            default:           cmd       = '0;
        endcase
    end

endmodule

@@ design/mse_dpath.sv @@
// Datapath: two element buffers, merge pointers, comparator, output register.
// Depends on mse_pkg, mse_ram and merge_sort_engine_assert.svh.
`include "merge_sort_engine_assert.svh"

module mse_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mse_pkg::mse_cmd_t                   cmd,
    output mse_pkg::mse_stat_t                  stat,
    input  logic                                item_valid,
    input  logic signed [mse_pkg::DATA_W-1:0]   value,
    input  logic                                last,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [mse_pkg::DATA_W-1:0]   sorted_value,
    output logic                                final_res,
    output logic                                overflow
);

    localparam int PW = mse_pkg::PTR_W;
    localparam int SW = mse_pkg::SUM_W;
    localparam int AW = mse_pkg::ADDR_W;
    localparam int DW = mse_pkg::DATA_W;

    logic [mse_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      drop_reg, drop_next;
    logic                      sel_reg, sel_next;    // 1: sorted data sits in scratch
    logic [PW-1:0]             width_reg, width_next;
    logic [PW-1:0]             a_reg, a_next;        // also emit pointer
    logic [PW-1:0]             b_reg, b_next;
    logic [PW-1:0]             mid_reg, mid_next;
    logic [PW-1:0]             hi_reg, hi_next;
    logic [PW-1:0]             k_reg, k_next;
    logic                      ov_reg, ov_next;
    logic [DW-1:0]             val_reg, val_next;
    logic                      fin_reg, fin_next;
    logic                      ovf_reg, ovf_next;

    logic [DW-1:0] p_q0, p_q1, s_q0, s_q1, qa, qb, merged;
    logic          p_we, s_we, accept, room, a_ok, b_ok, take_b;
    logic          pair_end, pass_end, out_load, emit_last;
    logic [PW-1:0] n_ext, k_inc, a_inc, w_dbl, base, wnext, mid_calc, hi_calc;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;

    // Buffers: both see the same addresses; sel_reg picks source and sink.
    mse_ram #(.WIDTH(DW), .DEPTH(mse_pkg::MAX_ELEMENTS)) u_primary (
        .clk    (clk),
        .we     (p_we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (a_next[AW-1:0]),
        .raddr1 (b_next[AW-1:0]),
        .rdata0 (p_q0),
        .rdata1 (p_q1)
    );

    mse_ram #(.WIDTH(DW), .DEPTH(mse_pkg::MAX_ELEMENTS)) u_scratch (
        .clk    (clk),
        .we     (s_we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (a_next[AW-1:0]),
        .raddr1 (b_next[AW-1:0]),
        .rdata0 (s_q0),
        .rdata1 (s_q1)
    );

    assign n_ext  = PW'(count_reg);
    assign accept = item_valid && cmd.load;
    assign room   = count_reg < mse_pkg::CNT_W'(mse_pkg::MAX_ELEMENTS);
    assign qa     = sel_reg ? s_q0 : p_q0;
    assign qb     = sel_reg ? s_q1 : p_q1;

    // merge step: head of run A at a_reg, head of run B at b_reg
    assign a_ok     = a_reg < mid_reg;
    assign b_ok     = b_reg < hi_reg;
    assign take_b   = b_ok && (!a_ok || ($signed(qb) < $signed(qa)));
    assign merged   = take_b ? qb : qa;
    assign k_inc    = k_reg + PW'(1);
    assign a_inc    = a_reg + PW'(1);
    assign pair_end = k_inc == hi_reg;
    assign pass_end = hi_reg == n_ext;
    assign w_dbl    = width_reg << 1;

    // bounds of the next run pair (setup starts pass one at width 1)
    always_comb
    begin
        if (cmd.setup)
        begin
            base  = '0;
            wnext = PW'(1);
        end
        else
        begin
            base  = pass_end ? '0 : hi_reg;
            wnext = pass_end ? w_dbl : width_reg;
        end
        mid_calc = mse_pkg::clamp_n(SW'(base) + SW'(wnext), n_ext);
        hi_calc  = mse_pkg::clamp_n(SW'(base) + (SW'(wnext) << 1), n_ext);
    end

    assign p_we  = (accept && room) || (cmd.merge && sel_reg);
    assign s_we  = cmd.merge && !sel_reg;
    assign waddr = cmd.merge ? k_reg[AW-1:0] : count_reg[AW-1:0];
    assign wdata = cmd.merge ? merged : value;

    assign out_load  = cmd.emit && (!ov_reg || res_ready);
    assign emit_last = a_inc == n_ext;

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        sel_next   = sel_reg;
        width_next = width_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && !res_ready;
        val_next   = val_reg;
        fin_next   = fin_reg;
        ovf_next   = ovf_reg;

        if (accept)
        begin
            if (room)
            begin
                count_next = count_reg + mse_pkg::CNT_W'(1);
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        if (cmd.setup)
        begin
            sel_next   = 1'b0;
            width_next = wnext;
            a_next     = '0;
            k_next     = '0;
            mid_next   = mid_calc;
            b_next     = mid_calc;
            hi_next    = hi_calc;
        end

        if (cmd.merge)
        begin
            if (pair_end)
            begin
                a_next     = base;
                k_next     = base;
                mid_next   = mid_calc;
                b_next     = mid_calc;
                hi_next    = hi_calc;
                width_next = wnext;
                sel_next   = sel_reg ^ pass_end;
            end
            else
            begin
                k_next = k_inc;
                if (take_b)
                begin
                    b_next = b_reg + PW'(1);
                end
                else
                begin
                    a_next = a_inc;
                end
            end
        end

        if (out_load)
        begin
            ov_next  = 1'b1;
            val_next = qa;
            fin_next = emit_last;
            ovf_next = drop_reg;
            a_next   = a_inc;
            if (emit_last)
            begin
                count_next = '0;
                drop_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            sel_reg   <= 1'b0;
            width_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            sel_reg   <= sel_next;
            width_reg <= width_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        fin_reg <= fin_next;
        ovf_reg <= ovf_next;
    end

    assign stat.last_acc  = accept && last;
    assign stat.single    = count_reg <= mse_pkg::CNT_W'(1);
    assign stat.sort_done = cmd.merge && pair_end && pass_end && (w_dbl >= n_ext);
    assign stat.emit_done = out_load && emit_last;

    assign res_valid    = ov_reg;
    assign sorted_value = val_reg;
    assign final_res    = fin_reg;
    assign overflow     = ovf_reg;

    `MSE_CHECK(a_count_range, count_reg <= mse_pkg::CNT_W'(mse_pkg::MAX_ELEMENTS),
        "element count beyond capacity")
    `MSE_CHECK(a_merge_ptrs,
        !cmd.merge || ((a_reg <= mid_reg) && (b_reg <= hi_reg) && (mid_reg <= hi_reg)),
        "merge pointers out of their runs")
    `MSE_CHECK(a_merge_sink, !cmd.merge || (k_reg == a_reg + b_reg - mid_reg),
        "merge write pointer disagrees with consumed heads")
    `MSE_CHECK_NEXT(a_emit_end, stat.emit_done, (count_reg == '0) && !drop_reg && final_res,
        "set not cleared after its final result")

endmodule

@@ design/merge_sort_engine.sv @@
// Top level of the merge sort engine.
// Depends on mse_pkg, mse_ctrl, mse_dpath (and through it mse_ram).
//
// Usage:
//   Input channel (item_valid/item_ready, value, last): one signed 32-bit
//   element per item. item_ready is high only while the set is loading.
//   Up to 32 elements are stored; further ones are dropped and the set is
//   flagged. The item with last set closes the set and starts the sort.
//   Output channel (res_valid/res_ready, sorted_value, final_res, overflow):
//   one item per stored element, ascending; final_res marks the last one,
//   overflow is high on every item of a set that lost elements.
//   Phases for a set of n elements: load, setup, then ceil(log2 n)
//   merge passes (one element written per cycle by the comparator between
//   the two buffer heads), then emit. The merge passes bound the rate.
//   A stalled receiver holds the output register and pauses the emit; the
//   next set may start loading while the final result still waits.
//   Reset (rst_n, asynchronous, active low) empties the set and clears the
//   output valid; buffer contents are not cleared and need not be.
module merge_sort_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [mse_pkg::DATA_W-1:0]  value,
    input  logic                               last,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic signed [mse_pkg::DATA_W-1:0]  sorted_value,
    output logic                               final_res,
    output logic                               overflow
);

    mse_pkg::mse_cmd_t  cmd;
    mse_pkg::mse_stat_t stat;

    // sequencer: decides phase from datapath status
    mse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // buffers, merge pointers and output register
    mse_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item_valid   (item_valid),
        .value        (value),
        .last         (last),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    // loading phase is the only time input items are taken
    assign item_ready = cmd.load;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for merge_sort_engine: random and directed sets of
// signed elements go in, each sorted run is checked against a local sort.
// Depends on mse_pkg and the merge_sort_engine RTL.
module testbench;

    typedef logic signed [mse_pkg::DATA_W-1:0] elem_t;

    // One expected output item.
    typedef struct packed {
        elem_t sorted_value;
        logic  final_res;
        logic  overflow;
    } sorted_item_t;

    localparam elem_t ELEM_MIN = {1'b1, {(mse_pkg::DATA_W-1){1'b0}}};
    localparam elem_t ELEM_MAX = {1'b0, {(mse_pkg::DATA_W-1){1'b1}}};

    // Element styles for the random generator
    localparam int STYLE_FULL    = 0;   // any 32-bit pattern
    localparam int STYLE_NARROW  = 1;   // small range, lots of duplicates
    localparam int STYLE_EXTREME = 2;   // corners of the signed range
    localparam int STYLE_MIX     = 3;   // one of the above per element

    localparam int TARGET_ITEMS  = 430;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  item_valid = 1'b0;
    logic  item_ready;
    elem_t value      = '0;
    logic  last       = 1'b0;
    logic  res_valid;
    logic  res_ready  = 1'b0;
    elem_t sorted_value;
    logic  final_res;
    logic  overflow;

    // Set being collected by the predictor, and results still owed by the DUT
    elem_t        set_store [mse_pkg::MAX_ELEMENTS];
    int           set_count   = 0;
    bit           set_dropped = 1'b0;
    sorted_item_t sorted_q [$];

    int error_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    // Receiver control: rx_hold forces a long stall, counted down below
    int rx_hold     = 0;
    int rx_seg_left = 0;
    int rx_seg_kind = 0;

    merge_sort_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .value        (value),
        .last         (last),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Predictor: store while there is room, otherwise flag the drop. On the
    // last item, sort what was kept and queue one result per element.
    function automatic void record_element(input elem_t v, input logic is_last);
        elem_t        key;
        int           i;
        int           j;
        sorted_item_t r;
        if (set_count < mse_pkg::MAX_ELEMENTS)
        begin
            set_store[set_count] = v;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (is_last)
        begin
            // insertion sort, signed compare
            for (i = 1; i < set_count; i++)
            begin
                key = set_store[i];
                j   = i - 1;
                while (j >= 0 && set_store[j] > key)
                begin
                    set_store[j+1] = set_store[j];
                    j--;
                end
                set_store[j+1] = key;
            end
            for (i = 0; i < set_count; i++)
            begin
                r.sorted_value = set_store[i];
                r.final_res    = (i == set_count - 1);
                r.overflow     = set_dropped;
                sorted_q.push_back(r);
            end
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endfunction

    function automatic elem_t pick_element(input int style);
        int s;
        s = (style == STYLE_MIX) ? $urandom_range(0, 2) : style;
        case (s)
            STYLE_NARROW:
                return elem_t'($urandom_range(0, 12)) - elem_t'(6);
            STYLE_EXTREME:
                case ($urandom_range(0, 5))
                    0:       return ELEM_MIN;
                    1:       return ELEM_MAX;
                    2:       return elem_t'(0);
                    3:       return elem_t'(-1);
                    4:       return ELEM_MIN + elem_t'(1);
                    default: return ELEM_MAX - elem_t'(1);
                endcase
            default:
                return elem_t'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted. Bursts of random length;
    // valid only drops at the end of a burst, then a random gap follows.
    task automatic offer_element(input elem_t v, input logic is_last);
        item_valid <= 1'b1;
        value      <= v;
        last       <= is_last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        record_element(v, is_last);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_set(input int len, input int style);
        int k;
        for (k = 0; k < len; k++)
            offer_element(pick_element(style), k == len - 1);
    endtask

    // Stop offering until every owed result has come out.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One-element sets at the signed extremes and zero: no merge pass at all.
    task automatic test_single_element();
        offer_element(ELEM_MIN, 1'b1);
        offer_element(ELEM_MAX, 1'b1);
        offer_element(elem_t'(0), 1'b1);
        wait_drained();
    endtask

    task automatic test_mixed_extremes();
        offer_element(ELEM_MAX, 1'b0);
        offer_element(ELEM_MIN, 1'b0);
        offer_element(elem_t'(0), 1'b0);
        offer_element(elem_t'(-1), 1'b0);
        offer_element(elem_t'(1), 1'b0);
        offer_element(ELEM_MIN + elem_t'(1), 1'b0);
        offer_element(ELEM_MAX - elem_t'(1), 1'b0);
        offer_element(ELEM_MIN, 1'b0);
        offer_element(elem_t'(32'h5555_aaaa), 1'b1);
        wait_drained();
    endtask

    // Duplicates: order among equal values does not show in the output.
    task automatic test_equal_values();
        offer_element(elem_t'(7), 1'b0);
        offer_element(elem_t'(-3), 1'b0);
        offer_element(elem_t'(7), 1'b0);
        offer_element(elem_t'(7), 1'b0);
        offer_element(elem_t'(-3), 1'b1);
        offer_element(elem_t'(-1), 1'b0);
        offer_element(elem_t'(-1), 1'b0);
        offer_element(elem_t'(-1), 1'b1);
        wait_drained();
    endtask

    // Exactly full (no flag), last item dropped, long overflow, then a small
    // set to see count and flag cleared.
    task automatic test_capacity();
        send_set(mse_pkg::MAX_ELEMENTS, STYLE_FULL);
        send_set(mse_pkg::MAX_ELEMENTS + 1, STYLE_MIX);
        send_set(mse_pkg::MAX_ELEMENTS + 8, STYLE_NARROW);
        send_set(3, STYLE_MIX);
        wait_drained();
    endtask

    // Receiver stalls for a long time while sets keep coming; the block has
    // to sit on its output and hold item_ready low.
    task automatic test_backpressure();
        rx_hold = 400;
        send_set(20, STYLE_MIX);
        send_set(12, STYLE_FULL);
        wait_drained();
    endtask

    // Mostly short sets, some medium, a few at or past capacity.
    task automatic test_random_sets();
        int pick;
        int len;
        while (items_sent < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(1, 8);
            else if (pick < 18)
                len = $urandom_range(9, mse_pkg::MAX_ELEMENTS - 1);
            else
                len = $urandom_range(mse_pkg::MAX_ELEMENTS, mse_pkg::MAX_ELEMENTS + 8);
            send_set(len, $urandom_range(STYLE_FULL, STYLE_MIX));
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Receiver: forced hold first, then segments of always-ready, random
    // stalls, or mostly stalled.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                res_ready <= 1'b0;
            end
            else
            begin
                if (rx_seg_left == 0)
                begin
                    rx_seg_kind = $urandom_range(0, 2);
                    rx_seg_left = $urandom_range(4, 40);
                end
                rx_seg_left--;
                case (rx_seg_kind)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= ($urandom_range(0, 2) != 0);
                    default: res_ready <= (rx_seg_left % 6 == 0);
                endcase
            end
        end
    end

    // Result checker: each accepted item against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        sorted_item_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (sorted_q.size() == 0)
            begin
                $error("unexpected item: sorted_value=%0d final_res=%0b overflow=%0b",
                       sorted_value, final_res, overflow);
                error_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (sorted_value !== want.sorted_value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, sorted_value);
                    error_count++;
                end
                if (final_res !== want.final_res)
                begin
                    $error("final_res: expected %0b, got %0b", want.final_res, final_res);
                    error_count++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: declares failure and ends the run if the tests hang.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_single_element();
        test_mixed_extremes();
        test_equal_values();
        test_capacity();
        test_backpressure();
        test_random_sets();

        // let any stray result show up before the verdict
        repeat (64) @(posedge clk);
        if (error_count == 0 && sorted_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
